/* hw/rtl/kscf_pkg.sv */
// Shared types, constants and layout tables for the keyboard scancode FIFO.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package kscf_pkg;

	localparam int BufferDepthDefault = 256;
	localparam int TableSize          = 80;
	localparam int CharWidth          = 7;
	localparam int FillWidth          = 9;

	localparam logic [7:0] ReleaseLimit = 8'd128;
	localparam logic [CharWidth-1:0] CtrlCCode = 7'd3;
	localparam logic [CharWidth-1:0] CharLowerC = 7'd99;
	localparam logic [CharWidth-1:0] CharUpperC = 7'd67;

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_IGNORED = 3'd1,
		ST_DROPPED = 3'd2,
		ST_READ_OK = 3'd3,
		ST_EMPTY   = 3'd4
	} kscf_status_t;

	typedef enum logic {
		OP_KEY  = 1'b0,
		OP_READ = 1'b1
	} kscf_op_t;

	// Result of one ring update, handed to the result pipeline
	typedef struct packed {
		kscf_status_t         status;
		logic [FillWidth-1:0] fill;
	} kscf_ring_res_t;

	typedef logic [CharWidth-1:0] kscf_char_t;

	// US layout, set-1 make codes 0..79, unshifted
	localparam kscf_char_t PlainMap [TableSize] = '{
		7'd0,   7'd27,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,
		7'd55,  7'd56,  7'd57,  7'd48,  7'd45,  7'd61,  7'd8,   7'd9,
		7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
		7'd111, 7'd112, 7'd91,  7'd93,  7'd10,  7'd0,   7'd97,  7'd115,
		7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,
		7'd39,  7'd96,  7'd0,   7'd92,  7'd122, 7'd120, 7'd99,  7'd118,
		7'd98,  7'd110, 7'd109, 7'd44,  7'd46,  7'd47,  7'd0,   7'd42,
		7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
		7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
		7'd0,   7'd0,   7'd45,  7'd0,   7'd0,   7'd0,   7'd43,  7'd0
	};

	// US layout, set-1 make codes 0..79, with shift
	localparam kscf_char_t ShiftedMap [TableSize] = '{
		7'd0,   7'd27,  7'd33,  7'd64,  7'd35,  7'd36,  7'd37,  7'd94,
		7'd38,  7'd42,  7'd40,  7'd41,  7'd95,  7'd43,  7'd8,   7'd9,
		7'd81,  7'd87,  7'd69,  7'd82,  7'd84,  7'd89,  7'd85,  7'd73,
		7'd79,  7'd80,  7'd123, 7'd125, 7'd10,  7'd0,   7'd65,  7'd83,
		7'd68,  7'd70,  7'd71,  7'd72,  7'd74,  7'd75,  7'd76,  7'd58,
		7'd34,  7'd126, 7'd0,   7'd124, 7'd90,  7'd88,  7'd67,  7'd86,
		7'd66,  7'd78,  7'd77,  7'd60,  7'd62,  7'd63,  7'd0,   7'd42,
		7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
		7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
		7'd0,   7'd0,   7'd45,  7'd0,   7'd0,   7'd0,   7'd43,  7'd0
	};

endpackage

`default_nettype wire

/* hw/rtl/kscf_if.sv */
// Request and response channel interfaces (valid/ready plus payload).
// Depends on kscf_pkg for the operation and status types.
`default_nettype none

interface kscf_req_if;
	import kscf_pkg::*;

	logic       valid;
	logic       ready;
	kscf_op_t   operation;
	logic [7:0] scancode;
	logic       shift_held;
	logic       ctrl_held;

	modport source (output valid, operation, scancode, shift_held, ctrl_held, input ready);
	modport sink   (input valid, operation, scancode, shift_held, ctrl_held, output ready);
endinterface

interface kscf_rsp_if;
	import kscf_pkg::*;

	logic                 valid;
	logic                 ready;
	kscf_status_t         status;
	logic [CharWidth-1:0] character;
	logic [FillWidth-1:0] fill_level;

	modport source (output valid, status, character, fill_level, input ready);
	modport sink   (input valid, status, character, fill_level, output ready);
endinterface

`default_nettype wire

/* hw/rtl/kscf_xlate.sv */
// Scancode to character translation through the fixed layout tables.
// Depends on kscf_pkg for PlainMap, ShiftedMap and the ctrl-c constants.
`default_nettype none

module kscf_xlate (
	input  wire logic [7:0]                 scancode,
	input  wire logic                       shift_held,
	input  wire logic                       ctrl_held,
	output      logic [kscf_pkg::CharWidth-1:0] character
);
	import kscf_pkg::*;

	logic       in_table;
	logic [6:0] idx;
	kscf_char_t raw;

	// Releases and codes past the table map to zero (ignored)
	assign in_table = (scancode < ReleaseLimit) && (scancode < 8'(TableSize));
	assign idx      = scancode[6:0];

	always_comb begin
		raw = '0;
		if (in_table) begin
			raw = shift_held ? ShiftedMap[idx] : PlainMap[idx];
		end
		character = raw;
		if (ctrl_held && (raw == CharLowerC || raw == CharUpperC)) begin
			character = CtrlCCode;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/kscf_ring.sv */
// Character ring buffer: pointers, fill count and storage array.
// Depends on kscf_pkg for the status type and result struct.
`default_nettype none

module kscf_ring #(
	parameter int BUFFER_DEPTH = kscf_pkg::BufferDepthDefault
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,
	input  wire logic                            is_read,
	input  wire logic [kscf_pkg::CharWidth-1:0]  push_char,
	output      kscf_pkg::kscf_ring_res_t        res,
	output      logic [kscf_pkg::CharWidth-1:0]  rd_data_q
);
	import kscf_pkg::*;

	localparam int PtrWidth = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CntWidth = $clog2(BUFFER_DEPTH + 1);

	kscf_char_t          mem [BUFFER_DEPTH];
	logic [PtrWidth-1:0] wr_ptr_q;
	logic [PtrWidth-1:0] rd_ptr_q;
	logic [CntWidth-1:0] cnt_q;
	logic [CntWidth-1:0] cnt_next;
	logic                empty;
	logic                full;
	logic                do_push;
	logic                do_pop;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CntWidth'(BUFFER_DEPTH));

	// Decide the outcome of this word
	always_comb begin
		do_push  = 1'b0;
		do_pop   = 1'b0;
		cnt_next = cnt_q;
		if (is_read) begin
			if (empty) begin
				res.status = ST_EMPTY;
			end else begin
				res.status = ST_READ_OK;
				do_pop     = 1'b1;
				cnt_next   = cnt_q - 1'b1;
			end
		end else if (push_char == '0) begin
			res.status = ST_IGNORED;
		end else if (full) begin
			res.status = ST_DROPPED;
		end else begin
			res.status = ST_STORED;
			do_push    = 1'b1;
			cnt_next   = cnt_q + 1'b1;
		end
		res.fill = FillWidth'(cnt_next);
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else if (step) begin
			cnt_q <= cnt_next;
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrWidth'(BUFFER_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrWidth'(BUFFER_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
		end
	end

	// Storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (step && do_push) begin
			mem[wr_ptr_q] <= push_char;
		end
		if (step && do_pop) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/keyboard_scancode_ascii_fifo_core.sv */
// Top level of the keyboard scancode FIFO: translation, ring and result pipeline.
// Depends on kscf_pkg, kscf_if, kscf_xlate and kscf_ring.
//
//   channel | dir | payload                                   | handshake
//   --------+-----+-------------------------------------------+------------
//   req     | in  | operation, scancode, shift_held, ctrl_held | valid/ready
//   rsp     | out | status, character, fill_level              | valid/ready
//
// One word in, one word out; a new word can be taken every cycle while rsp is not stalled.
// A word passes the ring update and read port at acceptance, then the output
// register (the ring's registered read port sets the first stage).
// arst_n clears pointers, fill count and both valid flags; storage is not cleared.
// A stall on rsp fills the two stages, then drops req.ready until one drains.
`default_nettype none

module keyboard_scancode_ascii_fifo_core #(
	parameter int BUFFER_DEPTH = kscf_pkg::BufferDepthDefault
) (
	input wire logic  clk,
	input wire logic  arst_n,
	kscf_req_if.sink  req,
	kscf_rsp_if.source rsp
);
	import kscf_pkg::*;

	kscf_char_t     key_char;
	kscf_char_t     rd_data_q;
	kscf_ring_res_t ring_res;
	logic           accept;
	logic           advance;

	logic                 valid_s1;
	kscf_status_t         status_s1;
	kscf_char_t           char_s1;
	logic [FillWidth-1:0] fill_s1;

	logic                 valid_s2;
	kscf_status_t         status_s2;
	kscf_char_t           char_s2;
	logic [FillWidth-1:0] fill_s2;

	kscf_xlate u_xlate (
		.scancode   (req.scancode),
		.shift_held (req.shift_held),
		.ctrl_held  (req.ctrl_held),
		.character  (key_char)
	);

	kscf_ring #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.is_read   (req.operation == OP_READ),
		.push_char (key_char),
		.res       (ring_res),
		.rd_data_q (rd_data_q)
	);

	// Handshake: stage 1 moves on when the output register is free or drains
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	// Stage 1 valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Stage 1 payload: hold until the word moves on
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= ring_res.status;
			fill_s1   <= ring_res.fill;
			char_s1   <= (req.operation == OP_READ) ? '0 : key_char;
		end
	end

	// Output payload: a popped character comes from the read port
	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_s1;
			fill_s2   <= fill_s1;
			char_s2   <= (status_s1 == ST_READ_OK) ? rd_data_q : char_s1;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.status     = status_s2;
	assign rsp.character  = char_s2;
	assign rsp.fill_level = fill_s2;

endmodule

`default_nettype wire

/* hw/rtl/kscf_checker.sv */
// Port-level checks on the response channel, bound to the top level.
// Depends on kscf_pkg for the status codes and field widths.
`default_nettype none

module kscf_checker #(
	parameter int BUFFER_DEPTH = kscf_pkg::BufferDepthDefault
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            rsp_valid,
	input wire logic                            rsp_ready,
	input wire logic [2:0]                      rsp_status,
	input wire logic [kscf_pkg::CharWidth-1:0]  rsp_character,
	input wire logic [kscf_pkg::FillWidth-1:0]  rsp_fill_level
);
	import kscf_pkg::*;

	localparam logic [FillWidth-1:0] FullFill = FillWidth'(BUFFER_DEPTH);

	// Hold a stalled word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_character) && $stable(rsp_fill_level))
		else $error("stalled response word changed");

	// Ignored keys and empty reads carry no character
	a_nochar: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_IGNORED || rsp_status == ST_EMPTY)
			|-> rsp_character == '0)
		else $error("character on ignored key or empty read");

	// An empty read sees an empty buffer
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_fill_level == '0)
		else $error("empty read with nonzero fill");

	// A drop only happens at full, and never with a null character
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_DROPPED |-> rsp_fill_level == FullFill
			&& rsp_character != '0)
		else $error("drop below full or with null character");

	// Stored characters are never null, and a store leaves a nonzero fill
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_STORED |-> rsp_character != '0
			&& rsp_fill_level != '0)
		else $error("stored word with null character or zero fill");

endmodule

bind keyboard_scancode_ascii_fifo_core kscf_checker #(
	.BUFFER_DEPTH (BUFFER_DEPTH)
) u_kscf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_character  (rsp.character),
	.rsp_fill_level (rsp.fill_level)
);

`default_nettype wire
